FILE: src/hsi2rgbw_pkg.sv
// Package with the payload types and sector codes of the HSI to RGBW converter.
`timescale 1ns / 1ps
`default_nettype none

package hsi2rgbw_pkg;

    // One input item: hue index and Q1.8 saturation and intensity.
    typedef struct packed {
        logic [7:0] hue;
        logic [8:0] saturation;
        logic [8:0] intensity;
    } hsi_in_t;

    // One result item: four 8-bit drive levels.
    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] white;
    } rgbw_out_t;

    // Sector codes, numbered as floor(3 * idx / HUE_STEPS).
    localparam logic [1:0] SECTOR_RED   = 2'd0;
    localparam logic [1:0] SECTOR_GREEN = 2'd1;
    localparam logic [1:0] SECTOR_BLUE  = 2'd2;

    // Unity for Q1.8 saturation and intensity.
    localparam logic [8:0] Q8_ONE = 9'd256;

    // Fixed-point constants for building the ratio table.
    localparam logic [63:0] PI_Q28       = 64'd843314857;
    localparam logic [63:0] ONE_Q28      = 64'd268435456;
    localparam int          TAYLOR_TERMS = 16;

    // Reciprocal of three for values below 1024: floor(q / 3) = (q * 683) >> 11.
    localparam logic [9:0] RECIP3_MUL   = 10'd683;
    localparam int         RECIP3_SHIFT = 11;

endpackage

`default_nettype wire

FILE: src/hsi_to_rgbw_converter_core.sv
// Top level of the HSI to RGBW converter: ratio table and five-stage datapath.
`timescale 1ns / 1ps
`default_nettype none

// Converts one HSI pixel to RGBW drive levels per clock while the output is not
// stalled. Every stage has its own valid bit and takes a new transfer whenever it
// is empty or its successor moves, so the block sustains one item per cycle while
// m_ready is high. A pixel passes through the stage registers in order before
// m_valid rises. The stages are: clamp and ratio table lookup, the two S*I
// products, the scale by 255 and white channel, the two ratio multiplies, and the
// divide by three with routing into the output register. The ratio table is a
// constant built at elaboration from RATIO_FRAC_BITS and HUE_STEPS and is indexed
// by the raw 8-bit hue.
module hsi_to_rgbw_converter_core #(
    parameter int RATIO_FRAC_BITS = 14,
    parameter int HUE_STEPS       = 256
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_valid,
    output logic                          s_ready,
    input  hsi2rgbw_pkg::hsi_in_t         s_data,
    output logic                          m_valid,
    input  wire                           m_ready,
    output hsi2rgbw_pkg::rgbw_out_t       m_data
);

    // Ratio entries reach 3 * 2^RATIO_FRAC_BITS.
    localparam int E_W   = RATIO_FRAC_BITS + 2;
    localparam int SI_W  = 17;
    localparam int S255_W = 25;
    localparam int P_W   = S255_W + E_W;
    localparam int Q_W   = P_W - 16 - RATIO_FRAC_BITS;
    localparam logic [E_W-1:0] E_TOP = E_W'(3) << RATIO_FRAC_BITS;

    // Shift and subtract quotient, used only while building the constant tables.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] quo;
        logic [64:0] rem;
        quo = '0;
        rem = '0;
        for (int j = 63; j >= 0; j--) begin
            rem = {rem[63:0], num[j]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[j] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Elaboration-time cosine: truncated Taylor series in Q28.
    function automatic logic signed [63:0] cos_q28(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        x2   = (x * x) >> 28;
        term = hsi2rgbw_pkg::ONE_Q28;
        sum  = $signed(hsi2rgbw_pkg::ONE_Q28);
        for (int k = 1; k <= hsi2rgbw_pkg::TAYLOR_TERMS; k++) begin
            term = udiv64((term * x2) >> 28, 64'(2 * k - 1) * 64'(2 * k));
            if ((k & 1) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        return sum;
    endfunction

    // Elaboration-time table entry: round((cos a + cos b) / cos b) in Q(RATIO_FRAC_BITS).
    function automatic logic [E_W-1:0] ratio_entry(input logic [63:0] idx);
        logic [63:0]        n;
        logic [63:0]        den;
        logic [63:0]        sector;
        logic [63:0]        m;
        logic [63:0]        a;
        logic [63:0]        d;
        logic [63:0]        b;
        logic signed [63:0] ca;
        logic signed [63:0] cb;
        logic signed [63:0] num;
        logic [63:0]        cbu;
        logic [63:0]        e;
        logic [63:0]        top;
        n      = 64'(HUE_STEPS);
        den    = 64'd3 * n;
        sector = udiv64(64'd3 * idx, n);
        m      = 64'd3 * idx - sector * n;
        a      = udiv64(64'd2 * hsi2rgbw_pkg::PI_Q28 * m + (den >> 1), den);
        d      = (n >= 64'd2 * m) ? (n - 64'd2 * m) : (64'd2 * m - n);
        b      = udiv64(hsi2rgbw_pkg::PI_Q28 * d + (den >> 1), den);
        ca     = cos_q28(a);
        cb     = cos_q28(b);
        num    = ca + cb;
        top    = 64'd3 << RATIO_FRAC_BITS;
        if (num <= 0 || cb <= 0) begin
            e = 64'd0;
        end else begin
            cbu = $unsigned(cb);
            e   = udiv64(($unsigned(num) << RATIO_FRAC_BITS) + (cbu >> 1), cbu);
            if (e > top) begin
                e = top;
            end
        end
        return E_W'(e);
    endfunction

    // Constant tables indexed by the raw hue.
    logic [E_W-1:0] rom_e   [256];
    logic [1:0]     rom_sec [256];

    for (genvar h = 0; h < 256; h++) begin : g_rom
        localparam int IDX = h % HUE_STEPS;
        // The computed sector number equals the package sector code.
        localparam logic [1:0]     SEC   = 2'((3 * IDX) / HUE_STEPS);
        localparam logic [E_W-1:0] ENTRY = ratio_entry(64'(IDX));
        assign rom_e[h]   = ENTRY;
        assign rom_sec[h] = SEC;
    end

    // Stage valid bits and per-stage ready.
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic rdy1, rdy2, rdy3, rdy4, rdy5;

    assign rdy5    = !v5_reg || m_ready;
    assign rdy4    = !v4_reg || rdy5;
    assign rdy3    = !v3_reg || rdy4;
    assign rdy2    = !v2_reg || rdy3;
    assign rdy1    = !v1_reg || rdy2;
    assign s_ready = rdy1;
    assign m_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else begin
            if (rdy1) v1_reg <= s_valid;
            if (rdy2) v2_reg <= v1_reg;
            if (rdy3) v3_reg <= v2_reg;
            if (rdy4) v4_reg <= v3_reg;
            if (rdy5) v5_reg <= v4_reg;
        end
    end

    // Stage 1: clamp and table lookup.
    logic [8:0]     s_next, i_next;
    logic [8:0]     s1_reg, i1_reg;
    logic [1:0]     sec1_reg;
    logic [E_W-1:0] e1_reg;

    always_comb begin
        s_next = (s_data.saturation > hsi2rgbw_pkg::Q8_ONE) ? hsi2rgbw_pkg::Q8_ONE
                                                           : s_data.saturation;
        i_next = (s_data.intensity > hsi2rgbw_pkg::Q8_ONE) ? hsi2rgbw_pkg::Q8_ONE
                                                          : s_data.intensity;
    end

    always_ff @(posedge aclk) begin
        if (rdy1) begin
            s1_reg   <= s_next;
            i1_reg   <= i_next;
            sec1_reg <= rom_sec[s_data.hue];
            e1_reg   <= rom_e[s_data.hue];
        end
    end

    // Stage 2: S*I and (1-S)*I.
    logic [SI_W-1:0] si2_reg, wi2_reg;
    logic [1:0]      sec2_reg;
    logic [E_W-1:0]  e2_reg;

    always_ff @(posedge aclk) begin
        if (rdy2) begin
            si2_reg  <= SI_W'(s1_reg) * SI_W'(i1_reg);
            wi2_reg  <= SI_W'(hsi2rgbw_pkg::Q8_ONE - s1_reg) * SI_W'(i1_reg);
            sec2_reg <= sec1_reg;
            e2_reg   <= e1_reg;
        end
    end

    // Stage 3: scale by 255 and finish the white channel.
    logic [S255_W-1:0] si3_reg;
    logic [7:0]        w3_reg;
    logic [1:0]        sec3_reg;
    logic [E_W-1:0]    e3_reg;
    logic [S255_W-1:0] wprod;

    // Largest product is 65536 * 255, so bits above 23 after the shift are zero.
    assign wprod = (S255_W'(wi2_reg) << 8) - S255_W'(wi2_reg);

    always_ff @(posedge aclk) begin
        if (rdy3) begin
            si3_reg  <= (S255_W'(si2_reg) << 8) - S255_W'(si2_reg);
            w3_reg   <= wprod[23:16];
            sec3_reg <= sec2_reg;
            e3_reg   <= e2_reg;
        end
    end

    // Stage 4: multiply by the ratio and its complement.
    logic [P_W-1:0] lp4_reg, np4_reg;
    logic [7:0]     w4_reg;
    logic [1:0]     sec4_reg;

    always_ff @(posedge aclk) begin
        if (rdy4) begin
            lp4_reg  <= P_W'(si3_reg) * P_W'(e3_reg);
            np4_reg  <= P_W'(si3_reg) * P_W'(E_TOP - e3_reg);
            w4_reg   <= w3_reg;
            sec4_reg <= sec3_reg;
        end
    end

    // Stage 5: divide by 3 * 2^(16 + RATIO_FRAC_BITS), clamp and route.
    localparam int RECIP_S = hsi2rgbw_pkg::RECIP3_SHIFT;
    logic [Q_W-1:0]          lq, nq;
    logic [Q_W+9:0]          lm, nm;
    logic [Q_W+9-RECIP_S:0]  ld, nd;
    logic [7:0]              lead_next, nxt_next;
    hsi2rgbw_pkg::rgbw_out_t out_next;
    hsi2rgbw_pkg::rgbw_out_t out_reg;

    always_comb begin
        lq = lp4_reg[P_W-1 -: Q_W];
        nq = np4_reg[P_W-1 -: Q_W];
        lm = (Q_W + 10)'(lq) * (Q_W + 10)'(hsi2rgbw_pkg::RECIP3_MUL);
        nm = (Q_W + 10)'(nq) * (Q_W + 10)'(hsi2rgbw_pkg::RECIP3_MUL);
        ld = lm[Q_W+9:RECIP_S];
        nd = nm[Q_W+9:RECIP_S];
        lead_next = (ld > 255) ? 8'd255 : ld[7:0];
        nxt_next  = (nd > 255) ? 8'd255 : nd[7:0];
        out_next.white = w4_reg;
        case (sec4_reg)
            hsi2rgbw_pkg::SECTOR_RED: begin
                out_next.red   = lead_next;
                out_next.green = nxt_next;
                out_next.blue  = 8'd0;
            end
            hsi2rgbw_pkg::SECTOR_GREEN: begin
                out_next.red   = 8'd0;
                out_next.green = lead_next;
                out_next.blue  = nxt_next;
            end
            hsi2rgbw_pkg::SECTOR_BLUE: begin
                out_next.red   = nxt_next;
                out_next.green = 8'd0;
                out_next.blue  = lead_next;
            end
            default: begin
                out_next.red   = 8'd0;
                out_next.green = 8'd0;
                out_next.blue  = 8'd0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rdy5) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench for the HSI to RGBW converter core.
`timescale 1ns / 1ps

module testbench;

    localparam int RATIO_FRAC_BITS = 14;
    localparam int HUE_STEPS       = 256;
    localparam int RANDOM_PIXELS   = 1230;
    localparam int PIPE_LATENCY    = 5;
    localparam int STALL_LIMIT     = 4000;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        hsi2rgbw_pkg::hsi_in_t   pixel;
        bit                      typed;
        hsi2rgbw_pkg::rgbw_out_t result;
    } pixel_case_t;

    logic                    aclk    = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    s_valid = 1'b0;
    hsi2rgbw_pkg::hsi_in_t   s_data  = '0;
    logic                    s_ready;
    logic                    m_valid;
    logic                    m_ready = 1'b0;
    hsi2rgbw_pkg::rgbw_out_t m_data;

    logic [63:0]             ratio_rom [HUE_STEPS];
    hsi2rgbw_pkg::rgbw_out_t expected_rgbw [$];
    pixel_case_t             directed_cases [$];

    bit idle_on = 1'b1;
    int stall_left = 0;
    int idle_cycles = 0;
    int fail_count = 0;
    int report_count = 0;
    int pixels_sent = 0;
    int clamped_count = 0;
    int lead_count [3] = '{0, 0, 0};

    hsi_to_rgbw_converter_core #(
        .RATIO_FRAC_BITS(RATIO_FRAC_BITS),
        .HUE_STEPS(HUE_STEPS)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_data(s_data),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_data(m_data)
    );

    always #10 aclk = ~aclk;

    // Cosine in signed Q28 by a truncated Taylor series.
    function automatic longint taylor_cos(input logic [63:0] angle);
        logic [63:0] sq;
        logic [63:0] term;
        longint      acc;
        sq = (angle * angle) >> 28;
        term = hsi2rgbw_pkg::ONE_Q28;
        acc = longint'(hsi2rgbw_pkg::ONE_Q28);
        for (int k = 1; k <= hsi2rgbw_pkg::TAYLOR_TERMS; k++) begin
            term = ((term * sq) >> 28) / (64'(2 * k - 1) * 64'(2 * k));
            if (k % 2 == 1) begin
                acc -= longint'(term);
            end else begin
                acc += longint'(term);
            end
        end
        return acc;
    endfunction

    // Ratio 1 + cos(a) / cos(60deg - a) in Q(RATIO_FRAC_BITS) for one hue index.
    function automatic logic [63:0] hue_ratio(input logic [63:0] idx);
        logic [63:0] steps;
        logic [63:0] den;
        logic [63:0] sector;
        logic [63:0] m;
        logic [63:0] ang_a;
        logic [63:0] ang_dist;
        logic [63:0] ang_b;
        logic [63:0] num_u;
        logic [63:0] cb_u;
        logic [63:0] ratio;
        logic [63:0] top;
        longint      ca;
        longint      cb;
        longint      num;
        steps = 64'(HUE_STEPS);
        den = 3 * steps;
        sector = (3 * idx) / steps;
        m = 3 * idx - sector * steps;
        ang_a = (2 * hsi2rgbw_pkg::PI_Q28 * m + den / 2) / den;
        ang_dist = (steps >= 2 * m) ? (steps - 2 * m) : (2 * m - steps);
        ang_b = (hsi2rgbw_pkg::PI_Q28 * ang_dist + den / 2) / den;
        ca = taylor_cos(ang_a);
        cb = taylor_cos(ang_b);
        num = ca + cb;
        top = 64'd3 << RATIO_FRAC_BITS;
        if (num <= 0 || cb <= 0) begin
            return 64'd0;
        end
        num_u = $unsigned(num);
        cb_u = $unsigned(cb);
        ratio = ((num_u << RATIO_FRAC_BITS) + cb_u / 2) / cb_u;
        return (ratio > top) ? top : ratio;
    endfunction

    function automatic logic [7:0] clip_level(input logic [63:0] v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic logic [1:0] lead_sector(input logic [7:0] hue);
        logic [63:0] idx;
        idx = 64'(hue % HUE_STEPS);
        return 2'((3 * idx) / HUE_STEPS);
    endfunction

    function automatic hsi2rgbw_pkg::rgbw_out_t convert_hsi(input hsi2rgbw_pkg::hsi_in_t pixel);
        logic [63:0]             sat;
        logic [63:0]             inten;
        logic [63:0]             ratio;
        logic [63:0]             si;
        logic [63:0]             scale;
        logic [7:0]              lead_level;
        logic [7:0]              trail_level;
        hsi2rgbw_pkg::rgbw_out_t res;
        sat = 64'((pixel.saturation > hsi2rgbw_pkg::Q8_ONE) ? hsi2rgbw_pkg::Q8_ONE
                                                             : pixel.saturation);
        inten = 64'((pixel.intensity > hsi2rgbw_pkg::Q8_ONE) ? hsi2rgbw_pkg::Q8_ONE
                                                              : pixel.intensity);
        ratio = ratio_rom[pixel.hue % HUE_STEPS];
        si = sat * inten * 255;
        scale = 64'd3 << (16 + RATIO_FRAC_BITS);
        lead_level = clip_level((si * ratio) / scale);
        trail_level = clip_level((si * ((64'd3 << RATIO_FRAC_BITS) - ratio)) / scale);
        res = '0;
        res.white = clip_level((255 * (64'd256 - sat) * inten) >> 16);
        case (lead_sector(pixel.hue))
            hsi2rgbw_pkg::SECTOR_RED: begin
                res.red = lead_level;
                res.green = trail_level;
            end
            hsi2rgbw_pkg::SECTOR_GREEN: begin
                res.green = lead_level;
                res.blue = trail_level;
            end
            default: begin
                res.blue = lead_level;
                res.red = trail_level;
            end
        endcase
        return res;
    endfunction

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end else if (r < 98) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [8:0] pick_level();
        int r;
        logic [8:0] corners [6];
        corners = '{9'd0, 9'd1, 9'd255, 9'd256, 9'd257, 9'd511};
        r = $urandom_range(0, 9);
        if (r < 6) begin
            return 9'($urandom_range(0, 256));
        end else if (r < 8) begin
            return 9'($urandom_range(0, 511));
        end
        return corners[$urandom_range(0, 5)];
    endfunction

    task automatic add_case(input logic [7:0] hue, input logic [8:0] sat, input logic [8:0] inten,
                            input bit typed, input logic [31:0] result);
        pixel_case_t c;
        c.pixel = '{hue: hue, saturation: sat, intensity: inten};
        c.typed = typed;
        c.result = result;
        directed_cases.push_back(c);
    endtask

    // Holds valid until the transfer happens, then records what must come out.
    task automatic send_pixel(input hsi2rgbw_pkg::hsi_in_t pixel, input bit typed,
                              input hsi2rgbw_pkg::rgbw_out_t result);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= pixel;
        do @(posedge aclk); while (!s_ready);
        expected_rgbw.push_back(typed ? result : convert_hsi(pixel));
        pixels_sent++;
        lead_count[lead_sector(pixel.hue)]++;
        if (pixel.saturation > hsi2rgbw_pkg::Q8_ONE || pixel.intensity > hsi2rgbw_pkg::Q8_ONE) begin
            clamped_count++;
        end
    endtask

    task automatic check_result(input hsi2rgbw_pkg::rgbw_out_t got);
        hsi2rgbw_pkg::rgbw_out_t want;
        if (expected_rgbw.size() == 0) begin
            fail_count++;
            report_count++;
            if (report_count <= REPORT_LIMIT) begin
                $display("Unexpected result transfer: r=%0d g=%0d b=%0d w=%0d",
                         got.red, got.green, got.blue, got.white);
            end
        end else begin
            want = expected_rgbw.pop_front();
            if (got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.white !== want.white) begin
                fail_count++;
                report_count++;
                if (report_count <= REPORT_LIMIT) begin
                    $display("Mismatch: expected r=%0d g=%0d b=%0d w=%0d,",
                             want.red, want.green, want.blue, want.white,
                             " got r=%0d g=%0d b=%0d w=%0d",
                             got.red, got.green, got.blue, got.white);
                end
            end
        end
    endtask

    // Result side: check every transfer and stall at random.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            check_result(m_data);
        end
        if (!idle_on) begin
            stall_left = 0;
        end
        if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            if (idle_on && $urandom_range(0, 99) < 20) begin
                stall_left = pick_gap();
            end
        end
    end

    // Watchdog: the run is stuck if no transfer happens on either side for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial begin
        hsi2rgbw_pkg::hsi_in_t pixel;
        int directed_total;
        for (int h = 0; h < HUE_STEPS; h++) begin
            ratio_rom[h] = hue_ratio(64'(h));
        end

        // Zero saturation or zero intensity gives results that need no predictor.
        add_case(8'd0,   9'd0,   9'd0,   1'b1, {8'd0, 8'd0, 8'd0, 8'd0});
        add_case(8'd255, 9'd511, 9'd0,   1'b1, {8'd0, 8'd0, 8'd0, 8'd0});
        add_case(8'd0,   9'd0,   9'd256, 1'b1, {8'd0, 8'd0, 8'd0, 8'd255});
        add_case(8'd128, 9'd0,   9'd511, 1'b1, {8'd0, 8'd0, 8'd0, 8'd255});
        add_case(8'd200, 9'd0,   9'd128, 1'b1, {8'd0, 8'd0, 8'd0, 8'd127});
        add_case(8'd170, 9'd0,   9'd257, 1'b1, {8'd0, 8'd0, 8'd0, 8'd255});
        // Sector edges at full saturation and intensity.
        add_case(8'd0,   9'd256, 9'd256, 1'b0, '0);
        add_case(8'd85,  9'd256, 9'd256, 1'b0, '0);
        add_case(8'd86,  9'd256, 9'd256, 1'b0, '0);
        add_case(8'd170, 9'd256, 9'd256, 1'b0, '0);
        add_case(8'd171, 9'd256, 9'd256, 1'b0, '0);
        add_case(8'd255, 9'd256, 9'd256, 1'b0, '0);
        // Clamping of out-of-range saturation and intensity.
        add_case(8'd42,  9'd511, 9'd511, 1'b0, '0);
        add_case(8'd43,  9'd257, 9'd300, 1'b0, '0);
        add_case(8'd100, 9'd300, 9'd200, 1'b0, '0);
        add_case(8'd254, 9'd2,   9'd510, 1'b0, '0);
        // Assorted mid-range and tiny values.
        add_case(8'd128, 9'd128, 9'd256, 1'b0, '0);
        add_case(8'd213, 9'd1,   9'd1,   1'b0, '0);
        add_case(8'd64,  9'd256, 9'd1,   1'b0, '0);
        add_case(8'd1,   9'd255, 9'd255, 1'b0, '0);
        add_case(8'd127, 9'd256, 9'd128, 1'b0, '0);

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_cases[n]) begin
            send_pixel(directed_cases[n].pixel, directed_cases[n].typed, directed_cases[n].result);
        end
        directed_total = directed_cases.size();

        for (int n = 0; n < RANDOM_PIXELS; n++) begin
            // A stretch with no idling on either side keeps the pipeline full.
            idle_on = !(n >= 300 && n < 450);
            if (n == 700) begin
                s_valid <= 1'b0;
                while (expected_rgbw.size() != 0) @(posedge aclk);
            end
            pixel.hue = 8'($urandom_range(0, 255));
            pixel.saturation = pick_level();
            pixel.intensity = pick_level();
            send_pixel(pixel, 1'b0, '0);
        end
        s_valid <= 1'b0;

        while (expected_rgbw.size() != 0) @(posedge aclk);
        repeat (4 * PIPE_LATENCY) @(posedge aclk);
        fail_count += expected_rgbw.size();

        $display("Converted %0d pixels (%0d from the directed table);", pixels_sent,
                 directed_total, " red, green, blue led %0d, %0d, %0d times.",
                 lead_count[0], lead_count[1], lead_count[2]);
        $display("%0d inputs had saturation or intensity clamped; %0d results failed the check.",
                 clamped_count, fail_count);
        if (fail_count == 0) begin
            $display("testbench OK");
        end else begin
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
